FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, always checked
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/ctag_pkg.sv
package ctag_pkg;

  localparam int NUM_LINES   = 8;
  localparam int BLOCK_WORDS = 4;
  localparam int ADDR_W      = 8;
  localparam int LINE_W      = $clog2(NUM_LINES);
  localparam int OFFS_W      = $clog2(BLOCK_WORDS);
  localparam int TAG_W       = ADDR_W - OFFS_W;
  localparam int CNT_W       = 16;
  localparam int OUT_W       = 1 + LINE_W + TAG_W + OFFS_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] HIT_MAX = '1;

  typedef enum logic {
    MODE_DIRECT = 1'b0,
    MODE_ASSOC  = 1'b1
  } map_mode_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic lookup;
  } ctl_cmd_t;

endpackage

FILE: hw/rtl/ctag_ctrl.sv
module ctag_ctrl
  import ctag_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = !rst && ((state == ST_EMPTY) || out_ready);
    out_valid  = !rst && (state == ST_FULL);
    cmd.lookup = in_valid && in_ready;
    unique case (state)
      ST_EMPTY: begin
        if (in_valid) begin
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        if (out_ready && !in_valid) begin
          state_next = ST_EMPTY;
        end
      end
      default: begin
        state_next = ST_EMPTY;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ctag_dp.sv
module ctag_dp
  import ctag_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctl_cmd_t          cmd,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic [ADDR_W-1:0] address,
  output logic              hit,
  output logic [LINE_W-1:0] line_used,
  output logic [TAG_W-1:0]  tag_value,
  output logic [OFFS_W-1:0] word_offset,
  output logic [CNT_W-1:0]  hit_total
);

  map_mode_t               mode;
  logic [NUM_LINES-1:0]    line_valid;
  logic [TAG_W-1:0]        line_tag [NUM_LINES];
  logic [LINE_W-1:0]       fill_ptr;
  logic [CNT_W-1:0]        hit_count;

  logic [TAG_W-1:0]        blk;
  logic [LINE_W-1:0]       d_line;
  logic [TAG_W-1:0]        d_tag;
  logic                    d_hit;
  logic [NUM_LINES-1:0]    a_match;
  logic [LINE_W-1:0]       a_line;
  logic                    lk_hit;
  logic [LINE_W-1:0]       lk_line;
  logic [TAG_W-1:0]        lk_tag;
  logic [CNT_W-1:0]        hit_count_next;

  always_comb begin
    blk    = address[ADDR_W-1:OFFS_W];
    d_line = blk[LINE_W-1:0];
    d_tag  = {{LINE_W{1'b0}}, blk[TAG_W-1:LINE_W]};
    d_hit  = line_valid[d_line] && (line_tag[d_line] == d_tag);
    a_line = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      a_match[i] = line_valid[i] && (line_tag[i] == blk);
      if (a_match[i]) begin
        a_line = LINE_W'(i);
      end
    end
    if (mode == MODE_ASSOC) begin
      lk_hit  = |a_match;
      lk_line = lk_hit ? a_line : fill_ptr;
      lk_tag  = blk;
    end else begin
      lk_hit  = d_hit;
      lk_line = d_line;
      lk_tag  = d_tag;
    end
    // saturating hit count
    if (lk_hit && (hit_count != HIT_MAX)) begin
      hit_count_next = hit_count + 1'b1;
    end else begin
      hit_count_next = hit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_DIRECT;
      line_valid <= '0;
      fill_ptr   <= '0;
      hit_count  <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode <= map_mode_t'(cfg_wr_data);
      end
      if (cmd.lookup) begin
        hit_count <= hit_count_next;
        if (!lk_hit) begin
          line_valid[lk_line] <= 1'b1;
          if (mode == MODE_ASSOC) begin
            fill_ptr <= fill_ptr + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      if (!lk_hit) begin
        line_tag[lk_line] <= lk_tag;
      end
      hit         <= lk_hit;
      line_used   <= lk_line;
      tag_value   <= lk_tag;
      word_offset <= address[OFFS_W-1:0];
      hit_total   <= hit_count_next;
    end
  end

endmodule

FILE: hw/rtl/cache_tag_hit_miss_model_top.sv
// Cache tag lookup for an 8-line cache with 4-word blocks and 8-bit word
// addresses. Each input item is one address; each yields exactly one result
// item with the hit flag, the line that hit or was filled, the tag, the word
// offset and a saturating 16-bit hit count. cfg_wr_data selects direct mapped
// (0) or fully associative with first-in first-out fill (1); write it only
// while the block is idle. The tag store is held in flip-flops with per-line
// valid bits cleared by reset, so the block takes items from the first cycle
// after reset. One address is taken per clock: the tag compare, the line
// update and the result register all happen in the accepting cycle, and
// results appear in the next cycle. The input stalls only while a finished
// result is waiting and the output side is not ready.
module cache_tag_hit_miss_model_top
  import ctag_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // address
  input  logic [ADDR_W-1:0]      s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit, line_used, tag_value, word_offset, hit_total, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ctl_cmd_t          cmd;
  logic              hit;
  logic [LINE_W-1:0] line_used;
  logic [TAG_W-1:0]  tag_value;
  logic [OFFS_W-1:0] word_offset;
  logic [CNT_W-1:0]  hit_total;

  ctag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  ctag_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .address     (s_axis_tdata),
    .hit         (hit),
    .line_used   (line_used),
    .tag_value   (tag_value),
    .word_offset (word_offset),
    .hit_total   (hit_total)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}},
                         hit_total, word_offset, tag_value, line_used, hit};

endmodule

FILE: hw/rtl/ctag_chk.sv
`include "assert_macros.svh"

module ctag_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic in_acc;
  logic out_wait;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_wait = m_axis_tvalid && !m_axis_tready;

  // a waiting result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  // every accepted item gives a result next cycle
  `ASSERT_NEXT(a_in_to_out, clk, rst, in_acc, m_axis_tvalid)
  // word offset follows the address of that item
  `ASSERT_NEXT(a_offset, clk, rst, in_acc, m_axis_tdata[11:10] == $past(s_axis_tdata[1:0]))
  // no result straight after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)
  // input is open whenever no result waits
  `ASSERT_IMPLY(a_ready_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

endmodule

bind cache_tag_hit_miss_model_top ctag_chk u_chk (.*);
